// ===== rtl/ttc_pkg.sv =====
package ttc_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int MAX_ROWS     = 1024;
   localparam int SAMPLE_WIDTH = 16;

   localparam int ROW_BITS  = $clog2(MAX_ROWS);
   localparam int ROWS_BITS = ROW_BITS + 1;
   localparam int CH_BITS   = $clog2(MAX_CHANNELS);
   localparam int FIELD_W   = 16;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [2:0] {
      ST_STOP  = 3'd0,
      ST_ARMED = 3'd1,
      ST_TRIG  = 3'd2,
      ST_WAIT  = 3'd3,
      ST_DONE  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_FORCE  = 3'd1,
      MODE_ARM    = 3'd2,
      MODE_STOP   = 3'd3,
      MODE_READ   = 3'd4,
      MODE_DONE   = 3'd5,
      MODE_SPARE6 = 3'd6,
      MODE_SPARE7 = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      REL_EQ   = 4'd0,
      REL_NE   = 4'd1,
      REL_LT   = 4'd2,
      REL_GT   = 4'd3,
      REL_ANY0 = 4'd4,
      REL_ANY1 = 4'd5,
      REL_ALL0 = 4'd6,
      REL_ALL1 = 4'd7,
      REL_NONE = 4'd8
   } relation_type;

   typedef enum logic [2:0] {
      REG_STEP      = 3'd0,
      REG_CHANNELS  = 3'd1,
      REG_ROWS      = 3'd2,
      REG_PERCENT   = 3'd3,
      REG_RELATION  = 3'd4,
      REG_THRESHOLD = 3'd5,
      REG_SIGNED    = 3'd6,
      REG_AUTO      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0] en;
      logic [ROW_BITS-1:0]     row;
      logic                    zero;
   } lane_write_type;

   typedef struct packed {
      logic [2:0]         state;
      logic               fired;
      logic               trig_row;
      logic [9:0]         oldest;
      logic               hit;
      logic [CH_BITS-1:0] channel;
   } rsp_meta_type;

endpackage

// ===== rtl/triggered_trace_capture.sv =====
// Triggered trace recorder: ticks are decimated by the step count, each kept tick
// in ST_ARMED/ST_TRIG writes the enabled channels as one row of a circular window,
// and a trigger relation on trigger_value (or a forced one) fires on its rising
// edge and leaves the post-trigger rows set by the trigger percentage. Every item
// gets one result item: lane data and request metadata are registered, then the
// result in the output register; one item is accepted per clock while the result
// side keeps up. Each channel has its own sample memory lane, so a whole row is
// written or read at once. After reset a clearing pass zeroes all 1024 rows, one
// row per cycle, with req_tready low; configuration writes are taken at any time.
module triggered_trace_capture
   import ttc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // trigger_value, ch0..ch7, read_row, read_channel
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [2:0]            req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // capture_state, trigger_fired, read_data, is_trigger_row, oldest_row
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data
);

   localparam int CH_LSB   = FIELD_W;
   localparam int RROW_LSB = FIELD_W + FIELD_W * MAX_CHANNELS;
   localparam int RCH_LSB  = RROW_LSB + 10;

   logic accept;
   logic clearing;
   logic stage_free;
   lane_write_type lane_write;
   logic [ROW_BITS-1:0] rd_row;
   rsp_meta_type meta;
   logic [MAX_CHANNELS-1:0][SAMPLE_WIDTH-1:0] lane_data;

   assign req_tready = !clearing && stage_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ttc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_mode          (req_tuser),
      .req_trigger_value (req_tdata[FIELD_W-1:0]),
      .req_read_row      (req_tdata[RROW_LSB +: 10]),
      .req_read_channel  (req_tdata[RCH_LSB +: 3]),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .clearing          (clearing),
      .lane_write        (lane_write),
      .rd_row            (rd_row),
      .meta              (meta)
   );

   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      logic [SAMPLE_WIDTH-1:0] wdata;

      assign wdata = lane_write.zero ? '0 : req_tdata[CH_LSB + FIELD_W * c +: SAMPLE_WIDTH];

      ttc_lane u_lane (
         .clock      (clock),
         .wr_en      (lane_write.en[c]),
         .wr_row     (lane_write.row),
         .wr_data    (wdata),
         .rd_en      (accept),
         .rd_row     (rd_row),
         .rd_data_ff (lane_data[c])
      );
   end

   ttc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .meta       (meta),
      .lane_data  (lane_data),
      .rsp_tready (rsp_tready),
      .stage_free (stage_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/ttc_lane.sv =====
module ttc_lane
   import ttc_pkg::*;
(
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ROW_BITS-1:0]     wr_row,
   input  logic [SAMPLE_WIDTH-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [ROW_BITS-1:0]     rd_row,
   output logic [SAMPLE_WIDTH-1:0] rd_data_ff
);

   logic [SAMPLE_WIDTH-1:0] mem [MAX_ROWS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

endmodule

// ===== rtl/ttc_ctrl.sv =====
module ttc_ctrl
   import ttc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [2:0]          req_mode,
   input  logic [FIELD_W-1:0]  req_trigger_value,
   input  logic [9:0]          req_read_row,
   input  logic [2:0]          req_read_channel,
   input  logic                csr_valid,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   output logic                clearing,
   output lane_write_type      lane_write,
   output logic [ROW_BITS-1:0] rd_row,
   output rsp_meta_type        meta
);

   localparam int PROD_BITS   = $clog2(MAX_ROWS * 99 + 1);
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_BITS  = 20;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((2 ** RECIP_SHIFT + 99) / 100);
   localparam logic [6:0] PCT_MAX = 7'd99;
   localparam logic [ROWS_BITS-1:0] ROWS_MAX = ROWS_BITS'(MAX_ROWS);
   localparam logic [3:0] CHANS_MAX = 4'(MAX_CHANNELS);

   status_type status_ff, status_in;
   logic [15:0] dec_ff, dec_in;
   logic [ROW_BITS-1:0] wr_ff, wr_in;
   logic [ROW_BITS-1:0] post_ff, post_in;
   logic force_ff, force_in;
   logic prev_ff, prev_in;

   logic [15:0] step_ff, step_in;
   logic [3:0] chans_ff, chans_in;
   logic [ROWS_BITS-1:0] rows_ff, rows_in;
   logic [6:0] pct_ff, pct_in;
   logic [3:0] rel_ff, rel_in;
   logic [15:0] thr_ff, thr_in;
   logic sgn_ff, sgn_in;
   logic auto_ff, auto_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;

   logic clear_ff, clear_in;
   logic [ROW_BITS-1:0] clear_row_ff, clear_row_in;

   logic [PROD_BITS+RECIP_BITS-1:0] trig_prod;
   logic [ROW_BITS-1:0] trig_row;
   logic [ROW_BITS-1:0] cur_row;
   logic [ROWS_BITS-1:0] cur_inc;
   logic [ROW_BITS-1:0] wr_next;
   logic [16:0] dec_next;
   logic keep;
   logic cond;
   logic now;
   logic fired;
   logic do_write;
   logic [ROWS_BITS-1:0] post_fire;
   logic [ROWS_BITS-1:0] rr_ext;
   logic [ROWS_BITS-1:0] phys_sum;
   logic [ROWS_BITS-1:0] phys;
   logic rr_in;
   logic [ROW_BITS-1:0] oldest;
   logic [15:0] pv;
   logic [ROWS_BITS-1:0] csr_rows;
   logic [6:0] csr_pct;

   assign trig_prod = (PROD_BITS+RECIP_BITS)'(prod_ff) * (PROD_BITS+RECIP_BITS)'(RECIP);
   assign trig_row  = trig_prod[RECIP_SHIFT +: ROW_BITS];
   assign cur_row   = (ROWS_BITS'(wr_ff) < rows_ff) ? wr_ff : '0;
   assign cur_inc   = ROWS_BITS'(cur_row) + ROWS_BITS'(1);
   assign wr_next   = (cur_inc >= rows_ff) ? '0 : cur_inc[ROW_BITS-1:0];
   assign dec_next  = {1'b0, dec_ff} + 17'd1;
   assign keep      = dec_next >= {1'b0, step_ff};
   assign post_fire = rows_ff - ROWS_BITS'(trig_row) - ROWS_BITS'(1);
   assign rr_ext    = ROWS_BITS'(req_read_row);
   assign rr_in     = rr_ext < rows_ff;
   assign phys_sum  = ROWS_BITS'(cur_row) + rr_ext;
   assign phys      = (phys_sum >= rows_ff) ? phys_sum - rows_ff : phys_sum;
   assign rd_row    = phys[ROW_BITS-1:0];
   assign pv        = req_trigger_value;
   assign csr_rows  = (csr_data[10:0] == '0) ? ROWS_BITS'(1) :
                      (ROWS_BITS'(csr_data[10:0]) > ROWS_MAX) ? ROWS_MAX :
                      ROWS_BITS'(csr_data[10:0]);
   assign csr_pct   = (csr_data[6:0] > PCT_MAX) ? PCT_MAX : csr_data[6:0];
   assign clearing  = clear_ff;

   always_comb begin
      case (rel_ff)
         REL_EQ:   cond = pv == thr_ff;
         REL_NE:   cond = pv != thr_ff;
         REL_LT:   cond = sgn_ff ? ($signed(pv) < $signed(thr_ff)) : (pv < thr_ff);
         REL_GT:   cond = sgn_ff ? ($signed(pv) > $signed(thr_ff)) : (pv > thr_ff);
         REL_ANY0: cond = (~pv & thr_ff) != '0;
         REL_ANY1: cond = (pv & thr_ff) != '0;
         REL_ALL0: cond = (~pv & thr_ff) == thr_ff;
         REL_ALL1: cond = (pv & thr_ff) == thr_ff;
         default:  cond = 1'b0;
      endcase
   end

   assign now = cond || force_ff;

   always_comb begin
      status_in    = status_ff;
      dec_in       = dec_ff;
      wr_in        = wr_ff;
      post_in      = post_ff;
      force_in     = force_ff;
      prev_in      = prev_ff;
      step_in      = step_ff;
      chans_in     = chans_ff;
      rows_in      = rows_ff;
      pct_in       = pct_ff;
      rel_in       = rel_ff;
      thr_in       = thr_ff;
      sgn_in       = sgn_ff;
      auto_in      = auto_ff;
      prod_in      = prod_ff;
      clear_in     = clear_ff;
      clear_row_in = clear_row_ff;
      fired        = 1'b0;
      do_write     = 1'b0;

      if (clear_ff) begin
         clear_row_in = clear_row_ff + ROW_BITS'(1);
         if (clear_row_ff == ROW_BITS'(MAX_ROWS - 1)) begin
            clear_in = 1'b0;
         end
      end

      if (accept) begin
         case (req_mode)
            MODE_TICK: begin
               if (!keep) begin
                  dec_in = dec_next[15:0];
               end else begin
                  dec_in = '0;
                  case (status_ff)
                     ST_ARMED: begin
                        force_in = 1'b0;
                        if (now && !prev_ff) begin
                           fired     = 1'b1;
                           post_in   = post_fire[ROW_BITS-1:0];
                           status_in = ST_TRIG;
                        end
                        prev_in = now;
                     end
                     ST_TRIG: begin
                        if (post_ff != '0) begin
                           post_in = post_ff - ROW_BITS'(1);
                        end else begin
                           status_in = ST_WAIT;
                        end
                     end
                     ST_DONE: status_in = auto_ff ? ST_ARMED : ST_STOP;
                     default: ;
                  endcase
                  if (status_in == ST_ARMED || status_in == ST_TRIG) begin
                     do_write = 1'b1;
                     wr_in    = wr_next;
                  end
               end
            end
            MODE_FORCE: force_in = 1'b1;
            MODE_ARM: begin
               if (status_ff == ST_STOP) begin
                  status_in = ST_ARMED;
               end
            end
            MODE_STOP: status_in = ST_STOP;
            MODE_DONE: begin
               if (status_ff == ST_WAIT) begin
                  status_in = ST_DONE;
               end
            end
            default: ;
         endcase
      end

      if (csr_valid) begin
         case (csr_index)
            REG_STEP: begin
               step_in   = (csr_data == '0) ? 16'd1 : csr_data;
               dec_in    = '0;
               status_in = ST_STOP;
            end
            REG_CHANNELS: begin
               chans_in  = (csr_data[3:0] > CHANS_MAX) ? CHANS_MAX : csr_data[3:0];
               status_in = ST_STOP;
            end
            REG_ROWS: begin
               rows_in   = csr_rows;
               prod_in   = PROD_BITS'(csr_rows) * PROD_BITS'(pct_ff);
               status_in = ST_STOP;
            end
            REG_PERCENT: begin
               pct_in    = csr_pct;
               prod_in   = PROD_BITS'(rows_ff) * PROD_BITS'(csr_pct);
               status_in = ST_STOP;
            end
            REG_RELATION: begin
               rel_in    = csr_data[3:0];
               status_in = ST_STOP;
            end
            REG_THRESHOLD: begin
               thr_in    = csr_data;
               status_in = ST_STOP;
            end
            REG_SIGNED: begin
               sgn_in    = csr_data[0];
               status_in = ST_STOP;
            end
            REG_AUTO: auto_in = csr_data[0];
            default: ;
         endcase
      end
   end

   assign oldest = (ROWS_BITS'(wr_in) < rows_ff) ? wr_in : '0;

   always_comb begin
      lane_write.row  = clear_ff ? clear_row_ff : cur_row;
      lane_write.zero = clear_ff;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         lane_write.en[c] = clear_ff || (do_write && (c < int'(chans_ff)));
      end
   end

   always_comb begin
      meta.state    = status_in;
      meta.fired    = fired;
      meta.trig_row = (req_mode == MODE_READ) && rr_in && (rr_ext == ROWS_BITS'(trig_row));
      meta.oldest   = 10'(oldest);
      meta.hit      = (req_mode == MODE_READ) && rr_in &&
                      ({1'b0, req_read_channel} < chans_ff);
      meta.channel  = CH_BITS'(req_read_channel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_STOP;
         dec_ff       <= '0;
         wr_ff        <= '0;
         post_ff      <= '0;
         force_ff     <= 1'b0;
         prev_ff      <= 1'b0;
         step_ff      <= 16'd1;
         chans_ff     <= 4'd0;
         rows_ff      <= ROWS_BITS'(10);
         pct_ff       <= 7'd50;
         rel_ff       <= REL_NONE;
         thr_ff       <= '0;
         sgn_ff       <= 1'b0;
         auto_ff      <= 1'b1;
         prod_ff      <= PROD_BITS'(500);
         clear_ff     <= 1'b1;
         clear_row_ff <= '0;
      end else begin
         status_ff    <= status_in;
         dec_ff       <= dec_in;
         wr_ff        <= wr_in;
         post_ff      <= post_in;
         force_ff     <= force_in;
         prev_ff      <= prev_in;
         step_ff      <= step_in;
         chans_ff     <= chans_in;
         rows_ff      <= rows_in;
         pct_ff       <= pct_in;
         rel_ff       <= rel_in;
         thr_ff       <= thr_in;
         sgn_ff       <= sgn_in;
         auto_ff      <= auto_in;
         prod_ff      <= prod_in;
         clear_ff     <= clear_in;
         clear_row_ff <= clear_row_in;
      end
   end

endmodule

// ===== rtl/ttc_merge.sv =====
module ttc_merge
   import ttc_pkg::*;
(
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  rsp_meta_type                             meta,
   input  logic [MAX_CHANNELS-1:0][SAMPLE_WIDTH-1:0] lane_data,
   input  logic                                     rsp_tready,
   output logic                                     stage_free,
   output logic                                     rsp_tvalid,
   output logic [RSP_DATA_W-1:0]                    rsp_tdata
);

   logic s1_valid_ff, s1_valid_in;
   rsp_meta_type s1_meta_ff;
   logic out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic advance;
   logic [15:0] rdata;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign stage_free = !s1_valid_ff || advance;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   assign rdata = s1_meta_ff.hit ? 16'(lane_data[s1_meta_ff.channel]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (advance) begin
         out_data_ff <= {1'b0, s1_meta_ff.oldest, s1_meta_ff.trig_row, rdata,
                         s1_meta_ff.fired, s1_meta_ff.state};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ttc_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_CHANNELS;

   // Packed in req_tdata order, highest field first.
   typedef struct packed {
      logic [2:0]        read_channel;
      logic [9:0]        read_row;
      logic [7:0][15:0]  ch;
      logic [15:0]       trig;
   } req_fields_type;

   typedef struct packed {
      logic        pad;
      logic [9:0]  oldest;
      logic        is_trig;
      logic [15:0] rdata;
      logic        fired;
      logic [2:0]  state;
   } trace_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [2:0]            csr_index = '0;
   logic [15:0]           csr_data = '0;

   int idle_pct = 8;
   int stall_pct = 8;
   int mismatches = 0;
   int rsp_seen = 0;
   int quiet_cycles = 0;

   trace_rsp_type expected_rsps[$];

   // Predictor copy of the registers.
   logic [15:0] p_step, p_thresh;
   logic [3:0]  p_chans, p_rel;
   logic [10:0] p_rows;
   logic [6:0]  p_pct;
   logic        p_signed, p_rearm;

   // Predictor copy of the capture state.
   status_type  cap_state;
   int          tick_count, wr_row, post_left;
   logic        force_hold, cond_last;
   logic [15:0] trace_mem [STORE_DEPTH];

   triggered_trace_capture uut (.*);

   initial forever #4 clock = ~clock;

   function automatic void reset_predictor();
      p_step = 16'd1;
      p_chans = 4'd0;
      p_rows = 11'd10;
      p_pct = 7'd50;
      p_rel = REL_NONE;
      p_thresh = 16'd0;
      p_signed = 1'b0;
      p_rearm = 1'b1;
      cap_state = ST_STOP;
      tick_count = 0;
      wr_row = 0;
      post_left = 0;
      force_hold = 1'b0;
      cond_last = 1'b0;
      foreach (trace_mem[i]) trace_mem[i] = '0;
   endfunction

   function automatic int rows_in_window();
      if (p_rows == 0) return 1;
      if (p_rows > MAX_ROWS) return MAX_ROWS;
      return int'(p_rows);
   endfunction

   function automatic int chans_on();
      return (p_chans > MAX_CHANNELS) ? MAX_CHANNELS : int'(p_chans);
   endfunction

   function automatic int trigger_row();
      int pct;
      pct = (p_pct > 99) ? 99 : int'(p_pct);
      return rows_in_window() * pct / 100;
   endfunction

   function automatic int current_row();
      return (wr_row < rows_in_window()) ? wr_row : 0;
   endfunction

   function automatic logic trigger_hit(logic [15:0] v);
      case (p_rel)
         REL_EQ:   return v == p_thresh;
         REL_NE:   return v != p_thresh;
         REL_LT:   return p_signed ? ($signed(v) < $signed(p_thresh)) : (v < p_thresh);
         REL_GT:   return p_signed ? ($signed(v) > $signed(p_thresh)) : (v > p_thresh);
         REL_ANY0: return (~v & p_thresh) != 16'd0;
         REL_ANY1: return (v & p_thresh) != 16'd0;
         REL_ALL0: return (~v & p_thresh) == p_thresh;
         REL_ALL1: return (v & p_thresh) == p_thresh;
         default:  return 1'b0;
      endcase
   endfunction

   function automatic void apply_csr(reg_index_type idx, logic [15:0] v);
      case (idx)
         REG_STEP: begin
            p_step = v;
            tick_count = 0;
         end
         REG_CHANNELS:  p_chans = v[3:0];
         REG_ROWS:      p_rows = v[10:0];
         REG_PERCENT:   p_pct = v[6:0];
         REG_RELATION:  p_rel = v[3:0];
         REG_THRESHOLD: p_thresh = v;
         REG_SIGNED:    p_signed = v[0];
         REG_AUTO:      p_rearm = v[0];
         default: ;
      endcase
      if (idx != REG_AUTO) cap_state = ST_STOP;
   endfunction

   function automatic trace_rsp_type predict_trace(logic [2:0] mode, req_fields_type f);
      trace_rsp_type r;
      int ns, nv, step, nxt, rw, phys;
      logic cond_now;
      r = '0;
      ns = rows_in_window();
      nv = chans_on();
      case (mode)
         MODE_TICK: begin
            step = (p_step == 16'd0) ? 1 : int'(p_step);
            nxt = tick_count + 1;
            if (nxt < step) begin
               tick_count = nxt;
            end else begin
               tick_count = 0;
               if (cap_state == ST_ARMED) begin
                  cond_now = trigger_hit(f.trig) || force_hold;
                  force_hold = 1'b0;
                  if (cond_now && !cond_last) begin
                     r.fired = 1'b1;
                     post_left = ns - trigger_row() - 1;
                     cap_state = ST_TRIG;
                  end
                  cond_last = cond_now;
               end else if (cap_state == ST_TRIG) begin
                  if (post_left != 0) post_left--;
                  else cap_state = ST_WAIT;
               end else if (cap_state == ST_DONE) begin
                  cap_state = p_rearm ? ST_ARMED : ST_STOP;
               end
               if (cap_state == ST_ARMED || cap_state == ST_TRIG) begin
                  rw = current_row();
                  for (int c = 0; c < nv; c++) trace_mem[rw * MAX_CHANNELS + c] = f.ch[c];
                  rw++;
                  wr_row = (rw >= ns) ? 0 : rw;
               end
            end
         end
         MODE_FORCE: force_hold = 1'b1;
         MODE_ARM:   if (cap_state == ST_STOP) cap_state = ST_ARMED;
         MODE_STOP:  cap_state = ST_STOP;
         MODE_READ: begin
            if (int'(f.read_row) < ns) begin
               phys = current_row() + int'(f.read_row);
               if (phys >= ns) phys -= ns;
               if (int'(f.read_channel) < nv)
                  r.rdata = trace_mem[phys * MAX_CHANNELS + int'(f.read_channel)];
               r.is_trig = (int'(f.read_row) == trigger_row());
            end
         end
         MODE_DONE:  if (cap_state == ST_WAIT) cap_state = ST_DONE;
         default: ;
      endcase
      r.state = cap_state;
      r.oldest = 10'(current_row());
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("result %0d: %s is %h, expected %h", rsp_seen, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : rsp_checker
      trace_rsp_type got, want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_tdata;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected item", 32'(got), '0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.state !== want.state)
               report_mismatch("capture_state", 32'(got.state), 32'(want.state));
            if (got.fired !== want.fired)
               report_mismatch("trigger_fired", 32'(got.fired), 32'(want.fired));
            if (got.rdata !== want.rdata)
               report_mismatch("read_data", 32'(got.rdata), 32'(want.rdata));
            if (got.is_trig !== want.is_trig)
               report_mismatch("is_trigger_row", 32'(got.is_trig), 32'(want.is_trig));
            if (got.oldest !== want.oldest)
               report_mismatch("oldest_row", 32'(got.oldest), 32'(want.oldest));
         end
         rsp_seen++;
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(mode_type mode, req_fields_type f);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser <= mode;
      req_tdata <= {3'b000, f};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_rsps.push_back(predict_trace(mode, f));
   endtask

   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [15:0] v);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      apply_csr(idx, v);
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] step, logic [15:0] chans, logic [15:0] rows,
                             logic [15:0] pct, logic [15:0] rel, logic [15:0] thr,
                             logic [15:0] sgn, logic [15:0] rearm);
      write_csr(REG_STEP, step);
      write_csr(REG_CHANNELS, chans);
      write_csr(REG_ROWS, rows);
      write_csr(REG_PERCENT, pct);
      write_csr(REG_RELATION, rel);
      write_csr(REG_THRESHOLD, thr);
      write_csr(REG_SIGNED, sgn);
      write_csr(REG_AUTO, rearm);
   endtask

   // Sets random bits above the register width now and then.
   function automatic logic [15:0] with_junk(logic [15:0] v, int width);
      logic [15:0] j;
      j = 16'($urandom);
      j = j << width;
      return ($urandom_range(3) == 0) ? (v | j) : v;
   endfunction

   function automatic req_fields_type make_fields(logic [15:0] trig, logic [15:0] fill,
                                                  logic [9:0] row, logic [2:0] chan);
      req_fields_type f;
      f.trig = trig;
      for (int c = 0; c < MAX_CHANNELS; c++) f.ch[c] = fill ^ {4{c[3:0]}};
      f.read_row = row;
      f.read_channel = chan;
      return f;
   endfunction

   function automatic logic [15:0] pick_trig();
      case ($urandom_range(5))
         0:       return p_thresh;
         1:       return p_thresh + 16'd1;
         2:       return p_thresh - 16'd1;
         3:       return 16'h0000;
         4:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_fields_type random_fields();
      req_fields_type f;
      f.trig = pick_trig();
      for (int c = 0; c < MAX_CHANNELS; c++) f.ch[c] = 16'($urandom);
      if ($urandom_range(99) < 85) f.read_row = 10'($urandom_range(rows_in_window() - 1));
      else f.read_row = 10'($urandom);
      f.read_channel = 3'($urandom);
      return f;
   endfunction

   function automatic mode_type pick_mode();
      int w;
      w = $urandom_range(99);
      if (cap_state == ST_STOP && w < 70) return MODE_ARM;
      if (cap_state == ST_WAIT && w < 60) return MODE_DONE;
      w = $urandom_range(99);
      if (w < 60) return MODE_TICK;
      if (w < 78) return MODE_READ;
      if (w < 84) return MODE_FORCE;
      if (w < 87) return MODE_STOP;
      if (w < 92) return MODE_ARM;
      if (w < 96) return MODE_DONE;
      return $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
   endfunction

   task automatic test_reset_state();
      send_item(MODE_READ, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'hFFFF, 16'hFFFF, 10'd0, 3'd0));
      send_item(MODE_READ, make_fields(16'h0000, 16'h0000, 10'd5, 3'd7));
   endtask

   task automatic test_directed_capture();
      set_config(16'd1, 16'd8, 16'd4, 16'd50, 16'(REL_EQ), 16'h8000, 16'd0, 16'd1);
      send_item(MODE_ARM, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'h0000, 16'hFFFF, 10'd0, 3'd0));
      send_item(MODE_FORCE, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_DONE, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'h8000, 16'h5A5A, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'hFFFF, 16'hA5A5, 10'd0, 3'd0));
      send_item(MODE_ARM, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_DONE, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'h8000, 16'h1234, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'h8000, 16'h4321, 10'd0, 3'd0));
      send_item(MODE_READ, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_READ, make_fields(16'h0000, 16'h0000, 10'd2, 3'd7));
      send_item(MODE_READ, make_fields(16'h0000, 16'h0000, 10'd3, 3'd3));
      send_item(MODE_READ, make_fields(16'hFFFF, 16'hFFFF, 10'h3FF, 3'd7));
      send_item(MODE_SPARE6, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_SPARE7, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_STOP, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
   endtask

   task automatic test_window_shrink();
      write_csr(REG_ROWS, 16'd1);
      send_item(MODE_READ, make_fields(16'h0000, 16'h0000, 10'd0, 3'd1));
      send_item(MODE_ARM, make_fields(16'h0000, 16'h0000, 10'd0, 3'd0));
      send_item(MODE_TICK, make_fields(16'h0000, 16'hC3C3, 10'd0, 3'd0));
      send_item(MODE_READ, make_fields(16'h0000, 16'h0000, 10'd0, 3'd1));
   endtask

   // Flavor 1 programs fixed small settings, 2 fixed large ones, others random.
   task automatic test_random_phase(int flavor, int n_items, bit paced);
      logic [15:0] step, chans, rows, pct, rel, thr, sgn, rearm;
      mode_type mode;
      case ($urandom_range(19))
         0:       step = 16'd0;
         1:       step = 16'hFFFF;
         2:       step = 16'($urandom);
         3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: step = 16'd1;
         default: step = 16'($urandom_range(2, 4));
      endcase
      case ($urandom_range(9))
         0:       chans = 16'd0;
         1:       chans = 16'd8;
         2:       chans = 16'($urandom);
         3:       chans = 16'd15;
         default: chans = with_junk(16'($urandom_range(1, 8)), 4);
      endcase
      case ($urandom_range(11))
         0:       rows = 16'd0;
         1:       rows = 16'd1;
         2:       rows = 16'd2;
         3:       rows = 16'd1024;
         4:       rows = with_junk(16'd2047, 11);
         5:       rows = 16'($urandom);
         default: rows = with_junk(16'($urandom_range(3, 16)), 11);
      endcase
      case ($urandom_range(9))
         0:       pct = 16'd0;
         1:       pct = 16'd99;
         2:       pct = with_junk(16'd127, 7);
         3:       pct = 16'd1;
         4:       pct = 16'($urandom);
         default: pct = with_junk(16'($urandom_range(1, 99)), 7);
      endcase
      rel = ($urandom_range(11) < 8) ? 16'($urandom_range(7)) : 16'($urandom_range(8, 15));
      rel = with_junk(rel, 4);
      case ($urandom_range(7))
         0:       thr = 16'h0000;
         1:       thr = 16'hFFFF;
         2:       thr = 16'h8000;
         3:       thr = 16'h7FFF;
         default: thr = 16'($urandom);
      endcase
      sgn = with_junk(16'($urandom_range(1)), 1);
      rearm = with_junk(($urandom_range(3) != 0) ? 16'd1 : 16'd0, 1);
      if (flavor == 1) begin
         step = 16'd1;
         chans = 16'd0;
         rows = 16'd1;
         pct = 16'd1;
         rel = 16'(REL_EQ);
         thr = 16'h0000;
         sgn = 16'd0;
         rearm = 16'd0;
      end else if (flavor == 2) begin
         step = 16'd1;
         chans = 16'd8;
         rows = 16'd1024;
         pct = 16'd99;
         rel = 16'(REL_NONE);
         thr = 16'hFFFF;
         sgn = 16'd1;
         rearm = 16'd1;
      end
      set_config(step, chans, rows, pct, rel, thr, sgn, rearm);
      repeat (n_items) begin
         mode = pick_mode();
         send_item(mode, random_fields());
         if (paced) drain(2);
      end
   endtask

   initial begin
      reset_predictor();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      drain(4);
      test_directed_capture();
      drain(4);
      test_window_shrink();
      drain(4);
      test_random_phase(1, 40, 1'b0);
      drain(4);
      test_random_phase(2, 40, 1'b0);
      drain(4);
      repeat (7) begin
         test_random_phase(0, 50, 1'b0);
         drain(4);
      end
      idle_pct = 0;
      stall_pct = 0;
      test_random_phase(0, 60, 1'b0);
      drain(4);
      idle_pct = 8;
      stall_pct = 8;
      test_random_phase(0, 30, 1'b1);
      drain(8);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
